/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/bua_pkg.sv */
// ----------------------------------------------------------------------------
// bua_pkg
// Types, constants and helpers for the alpha un-premultiply pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bua_pkg;

  localparam int ColorW     = 8;
  localparam int NumColors  = 3;             // 0 blue, 1 green, 2 red
  localparam int QuoW       = ColorW;
  localparam int RemW       = 2 * ColorW;
  localparam int StepBits   = 2;             // quotient bits per divider stage
  localparam int DivStages  = QuoW / StepBits;
  localparam int PipeDepth  = DivStages + 1;
  localparam int PosW       = $clog2(QuoW);
  localparam int ApbAddrW   = 3;
  localparam int ApbDataW   = 32;

  localparam logic [ColorW-1:0] FULL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_MONO  = 2'd0,
    MODE_BGR   = 2'd1,
    MODE_BGRA  = 2'd2,
    MODE_SPARE = 2'd3
  } depth_mode_t;

  typedef enum logic [0:0] {
    REG_DEPTH_MODE = 1'b0,
    REG_ALPHA_AUTO = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [NumColors-1:0][RemW-1:0]   rem;
    logic [NumColors-1:0][QuoW-1:0]   quo;
    logic [NumColors-1:0][ColorW-1:0] raw;
    logic [NumColors-1:0]             div_en;
    logic [ColorW-1:0]                divisor;
    logic [ColorW-1:0]                alpha;
    logic                             last;
    logic                             keep;
  } pix_stage_t;

  // One restoring step: {quotient bit, new remainder}.
  function automatic logic [RemW:0] div_step(input logic [RemW-1:0] rem,
                                             input logic [ColorW-1:0] d,
                                             input logic [PosW-1:0] pos);
    logic [RemW-1:0] sub;
    sub = {{(RemW-ColorW){1'b0}}, d} << pos;
    if (rem >= sub) begin
      return {1'b1, rem - sub};
    end
    return {1'b0, rem};
  endfunction

endpackage

/* rtl/bua_pix_in_if.sv */
// ----------------------------------------------------------------------------
// bua_pix_in_if
// Source pixel channel: valid/ready with one BGRA or mono pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bua_pix_in_if
  import bua_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] blue_in;
  logic [ColorW-1:0] green_in;
  logic [ColorW-1:0] red_in;
  logic [ColorW-1:0] alpha_in;
  logic              mono_bit;
  logic              last_pixel;

  modport source (output valid, blue_in, green_in, red_in, alpha_in, mono_bit,
                  last_pixel, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, alpha_in, mono_bit,
                  last_pixel, output ready);
endinterface

/* rtl/bua_pix_out_if.sv */
// ----------------------------------------------------------------------------
// bua_pix_out_if
// Result pixel channel: valid/ready with one straight RGBA pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bua_pix_out_if
  import bua_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red_out;
  logic [ColorW-1:0] green_out;
  logic [ColorW-1:0] blue_out;
  logic [ColorW-1:0] alpha_out;
  logic              last_out;
  logic              keep_alpha;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out,
                  keep_alpha, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_out,
                  keep_alpha, output ready);
endinterface

/* rtl/bgra_unpremultiply_alpha_classify.sv */
// ----------------------------------------------------------------------------
// bgra_unpremultiply_alpha_classify
// Converts premultiplied BGRA / BGR / mono pixels to straight RGBA and
// classifies the alpha content of each image.
// ----------------------------------------------------------------------------
//
//   channel   | kind        | transfer when
//   ----------+-------------+-----------------------------
//   pix_in    | pixel sink  | pix_in.valid & pix_in.ready
//   pix_out   | pixel src   | pix_out.valid & pix_out.ready
//   APB       | config regs | psel & penable & pwrite & pready
//
// One pixel per clock sustained while pix_out.ready holds; the input transfer
// loads the entry stage, then four radix-4 restoring divide stages resolve
// colour*255/alpha before the result is offered on pix_out.
// Reset (rst, synchronous) sets depth_mode=1, alpha_auto=1, clears the
// alpha flags and empties the pipeline.
// Each stage holds its item only while the stage after it is full and
// stalled, so bubbles are squeezed out and a stalled output never
// blocks input while an earlier stage is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bgra_unpremultiply_alpha_classify
  import bua_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  bua_pix_in_if.sink          pix_in,
  bua_pix_out_if.source       pix_out
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  depth_mode_t depth_mode;
  logic        alpha_auto;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= MODE_BGR;
      alpha_auto <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEPTH_MODE: depth_mode <= depth_mode_t'(pwdata[1:0]);
        REG_ALPHA_AUTO: alpha_auto <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEPTH_MODE: prdata = {{(ApbDataW-2){1'b0}}, depth_mode};
      REG_ALPHA_AUTO: prdata = {{(ApbDataW-1){1'b0}}, alpha_auto};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Entry stage: mode decode, alpha classification, dividend setup
  // --------------------------------------------------------------------------
  logic                             in_xfer;
  logic                             is_mono;
  logic                             is_bgra;
  logic                             a_zero;
  logic                             a_full;
  logic                             a_part;
  logic [NumColors-1:0][ColorW-1:0] in_color;
  logic                             seen_partial;
  logic                             seen_opaque;
  logic                             seen_clear;
  logic                             seen_partial_next;
  logic                             seen_opaque_next;
  logic                             seen_clear_next;
  pix_stage_t                       entry;

  assign in_xfer     = pix_in.valid && pix_in.ready;
  assign is_mono     = (depth_mode == MODE_MONO);
  assign is_bgra     = (depth_mode == MODE_BGRA);
  assign a_zero      = (pix_in.alpha_in == '0);
  assign a_full      = (pix_in.alpha_in == FULL_BYTE);
  assign a_part      = !a_zero && !a_full;
  assign in_color[0] = pix_in.blue_in;
  assign in_color[1] = pix_in.green_in;
  assign in_color[2] = pix_in.red_in;

  // Flags including the current pixel; only 32-bit pixels count.
  assign seen_partial_next = seen_partial || (is_bgra && a_part);
  assign seen_opaque_next  = seen_opaque  || (is_bgra && a_full);
  assign seen_clear_next   = seen_clear   || (is_bgra && a_zero);

  always_comb begin
    entry = '0;
    for (int c = 0; c < NumColors; c++) begin
      // colour*255 as (colour<<8) - colour
      entry.rem[c] = {in_color[c], {ColorW{1'b0}}} - {{ColorW{1'b0}}, in_color[c]};
      entry.quo[c] = '0;
      // Division only needed when the quotient lands below 255.
      entry.div_en[c] = is_bgra && !a_zero && (in_color[c] < pix_in.alpha_in);
      if (is_mono) begin
        entry.raw[c] = pix_in.mono_bit ? FULL_BYTE : '0;
      end else if (is_bgra && !a_zero) begin
        entry.raw[c] = FULL_BYTE;          // colour >= alpha saturates
      end else begin
        entry.raw[c] = in_color[c];        // BGR, spare code, or zero alpha
      end
    end
    entry.divisor = pix_in.alpha_in;
    entry.alpha   = is_bgra ? pix_in.alpha_in : FULL_BYTE;
    entry.last    = pix_in.last_pixel;
    entry.keep    = pix_in.last_pixel && is_bgra &&
                    (seen_partial_next || (seen_opaque_next && seen_clear_next) ||
                     !alpha_auto);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_partial <= 1'b0;
      seen_opaque  <= 1'b0;
      seen_clear   <= 1'b0;
    end else if (in_xfer) begin
      if (pix_in.last_pixel) begin
        seen_partial <= 1'b0;
        seen_opaque  <= 1'b0;
        seen_clear   <= 1'b0;
      end else begin
        seen_partial <= seen_partial_next;
        seen_opaque  <= seen_opaque_next;
        seen_clear   <= seen_clear_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline: stage 0 holds the entry result, stages 1..DivStages each
  // resolve StepBits quotient bits, MSB first.
  // --------------------------------------------------------------------------
  pix_stage_t             stage [PipeDepth];
  logic [PipeDepth-1:0]   vld;
  logic [PipeDepth-1:0]   adv;

  function automatic pix_stage_t div_stage(input pix_stage_t s, input int k);
    pix_stage_t      r;
    logic [RemW:0]   res;
    logic [PosW-1:0] pos;
    r = s;
    for (int c = 0; c < NumColors; c++) begin
      for (int j = 0; j < StepBits; j++) begin
        pos          = PosW'(QuoW - 1 - StepBits * k - j);
        res          = div_step(r.rem[c], r.divisor, pos);
        r.quo[c][pos] = res[RemW];
        r.rem[c]     = res[RemW-1:0];
      end
    end
    return r;
  endfunction

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[PipeDepth-1] = !vld[PipeDepth-1] || pix_out.ready;
    for (int i = PipeDepth - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign pix_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int i = 1; i < PipeDepth; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      stage[0] <= entry;
    end
    for (int i = 1; i < PipeDepth; i++) begin
      if (adv[i]) begin
        stage[i] <= div_stage(stage[i-1], i - 1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output
  // --------------------------------------------------------------------------
  pix_stage_t                       tail;
  logic [NumColors-1:0][ColorW-1:0] out_color;

  assign tail = stage[PipeDepth-1];

  always_comb begin
    for (int c = 0; c < NumColors; c++) begin
      out_color[c] = tail.div_en[c] ? tail.quo[c] : tail.raw[c];
    end
  end

  assign pix_out.valid      = vld[PipeDepth-1];
  assign pix_out.blue_out   = out_color[0];
  assign pix_out.green_out  = out_color[1];
  assign pix_out.red_out    = out_color[2];
  assign pix_out.alpha_out  = tail.alpha;
  assign pix_out.last_out   = tail.last;
  assign pix_out.keep_alpha = tail.keep;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic last_xfer;
  logic flags_idle;
  logic out_jammed;

  assign last_xfer  = in_xfer && pix_in.last_pixel;
  assign flags_idle = !seen_partial && !seen_opaque && !seen_clear;
  assign out_jammed = pix_out.valid && !pix_out.ready && (&vld);

  `ASSERT_NEXT(a_flags_clear_after_last, clk, rst, last_xfer, flags_idle)
  `ASSERT_SAME(a_keep_only_on_last, clk, rst, pix_out.valid && pix_out.keep_alpha, pix_out.last_out)
  `ASSERT_SAME(a_backpressure_source, clk, rst, !pix_in.ready, out_jammed)

endmodule
